/* src/block_owner_allocator_unit_defines.svh */
// assertion macros for the block owner allocator
// used by block_owner_allocator_unit; expects clk and rst in scope
`ifndef BLOCK_OWNER_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_OWNER_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/boa_pkg.sv */
// shared constants and codes for the block owner allocator
// no dependencies; used by the top level and the testbench
package boa_pkg;

  // table geometry
  localparam int BLOCKS    = 64;
  localparam int MAX_FILES = 16;
  localparam int ADDR_W    = $clog2(BLOCKS);
  localparam int CNT_W     = $clog2(BLOCKS + 1);
  localparam int SLOT_W    = 4;
  localparam int OWNER_W   = 5;
  localparam int COUNT_W   = 7;
  localparam int ACTIVE_W  = 7;
  localparam int FUNC_W    = 3;
  localparam int CODE_W    = 2;
  localparam int FILES_W   = 5;

  // stream and register port widths
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;
  localparam int APB_A_W  = 3;
  localparam int APB_D_W  = 32;

  // register map, selected by paddr[2]
  localparam logic REG_ACTIVE_BLOCKS = 1'b0;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd50;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEFRAG = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STATUS = 3'd4;
  localparam logic [FUNC_W-1:0] FN_MAP    = 3'd5;

  // result codes
  localparam logic [CODE_W-1:0] RC_OK      = 2'd0;
  localparam logic [CODE_W-1:0] RC_EXISTS  = 2'd1;
  localparam logic [CODE_W-1:0] RC_NOSPACE = 2'd2;
  localparam logic [CODE_W-1:0] RC_NOFILE  = 2'd3;

  typedef logic [OWNER_W-1:0] owner_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

/* src/boa_ram.sv */
// generic single-write, single-read ram with registered read data
// depends on nothing; read data holds while re is low
module boa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/block_owner_allocator_unit.sv */
// block owner allocator: first-fit block allocation over an owner table with compaction
// depends on boa_pkg, boa_ram and block_owner_allocator_unit_defines.svh
//
// usage
//   requests enter on the s_ channel (s_tuser = func, s_tdata = slot and count) and
//   results leave on the m_ channel, m_tlast marking the final result of a request.
//   the user must write active_blocks over the apb port only while the block is idle; the block does not enforce this.
//   one request is handled at a time; s_tready is high only when the block is idle.
//   every operation walks the owner ram one entry per cycle, but for receiver stalls
//   (one read port, registered read data); with A = min(active_blocks, 64), create
//   and read walk A entries in a counting pass, then in an action pass if there is
//   space or a block to report; delete walks all 64 entries once; status and map walk
//   A entries once (map none if A is zero); defrag counts all 64 entries, then rewrites
//   them slot by slot; exists, no file and unused func values go straight to a result.
//   read and map emit one result per cycle while m_tready stays high.
//   after reset every block reads as free at once: one valid bit per ram entry
//   masks entries never written, so there is no clearing pass.
//   when the receiver stalls, the walk halts on the current entry with the ram
//   output held, and resumes when the output register drains.
//   the output register lets a new result load in the cycle the old one is taken.
`include "block_owner_allocator_unit_defines.svh"

module block_owner_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [boa_pkg::S_DATA_W-1:0] s_tdata,   // [3:0] file_slot, [10:4] block_count
  input  logic [boa_pkg::FUNC_W-1:0]   s_tuser,   // [2:0] func
  // result channel
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [boa_pkg::M_DATA_W-1:0] m_tdata,   // [1:0] result_code, [7:2] block_index,
                                                  // [12:8] block_owner, [19:13] free_blocks,
                                                  // [24:20] file_count
  output logic                         m_tuser,   // [0] block_valid
  output logic                         m_tlast,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [boa_pkg::APB_A_W-1:0]  paddr,
  input  logic [boa_pkg::APB_D_W-1:0]  pwdata,
  output logic [boa_pkg::APB_D_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW = boa_pkg::ADDR_W;
  localparam int CW = boa_pkg::CNT_W;
  localparam int OW = boa_pkg::OWNER_W;
  localparam int SW = boa_pkg::SLOT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_PACK,
    ST_RESP
  } state_t;

  state_t state;

  // request and walk registers
  logic [boa_pkg::FUNC_W-1:0]  op;
  logic [SW-1:0]               slot;
  logic [boa_pkg::COUNT_W-1:0] count;
  boa_pkg::cnt_t               scan_end;
  boa_pkg::cnt_t               rd_addr;
  logic                        pend;
  logic [AW-1:0]               pend_addr;
  boa_pkg::cnt_t               tally;
  boa_pkg::cnt_t               k;
  logic [SW:0]                 cur_slot;
  boa_pkg::cnt_t               cnt [boa_pkg::MAX_FILES];
  logic [boa_pkg::CODE_W-1:0]  resp_code;
  boa_pkg::cnt_t               resp_free;
  logic [boa_pkg::FILES_W-1:0] resp_files;

  // directory state
  logic [boa_pkg::MAX_FILES-1:0] slot_present;
  logic [boa_pkg::FILES_W-1:0]   files_present;
  logic [boa_pkg::BLOCKS-1:0]    entry_valid;
  logic [boa_pkg::ACTIVE_W-1:0]  active_blocks;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  boa_pkg::owner_t ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  boa_pkg::owner_t ram_rdata;

  // combinational helpers
  boa_pkg::cnt_t   act;
  boa_pkg::owner_t cur_own;
  boa_pkg::owner_t slot_own;
  logic            can_emit;
  logic            in_scan;
  logic            need_emit;
  logic            stall;
  logic            scan_done;
  logic            pack_zero;
  boa_pkg::cnt_t   pack_cnt;
  logic            emit;
  logic [boa_pkg::CODE_W-1:0]  out_code;
  logic [AW-1:0]               out_index;
  boa_pkg::owner_t             out_owner;
  logic                        out_valid;
  boa_pkg::cnt_t               out_free;
  logic [boa_pkg::FILES_W-1:0] out_files;
  logic                        out_last;
  logic                        cfg_wr;

  boa_ram #(
    .WIDTH (OW),
    .DEPTH (boa_pkg::BLOCKS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective active block count
  assign act = (active_blocks > boa_pkg::ACTIVE_W'(boa_pkg::BLOCKS)) ?
               CW'(boa_pkg::BLOCKS) : CW'(active_blocks);

  // entries never written read as free
  assign cur_own  = entry_valid[pend_addr] ? ram_rdata : '0;
  assign slot_own = OW'(slot) + OW'(1);
  assign can_emit = !m_tvalid || m_tready;
  assign in_scan  = (state == ST_SCAN1) || (state == ST_SCAN2);

  // action pass of read and map produces results and may stall on the output
  assign need_emit = (state == ST_SCAN2) && pend &&
                     ((op == boa_pkg::FN_MAP) ||
                      ((op == boa_pkg::FN_READ) && (cur_own == slot_own)));
  assign stall     = need_emit && !can_emit;
  assign ram_re    = in_scan && !stall && (rd_addr < scan_end);
  assign ram_raddr = rd_addr[AW-1:0];
  assign scan_done = in_scan && !pend && (rd_addr == scan_end);

  // compaction writer: slot being laid down and its remaining blocks
  assign pack_zero = (cur_slot == (SW+1)'(boa_pkg::MAX_FILES));
  assign pack_cnt  = cnt[cur_slot[SW-1:0]];

  // owner ram writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = '0;
    case (state)
      ST_SCAN2: begin
        if (pend && (op == boa_pkg::FN_CREATE) && (cur_own == '0) &&
            (k < CW'(count))) begin
          ram_we    = 1'b1;
          ram_wdata = slot_own;
        end else if (pend && (op == boa_pkg::FN_DELETE) && (cur_own == slot_own)) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
      end
      ST_PACK: begin
        if ((k != CW'(boa_pkg::BLOCKS)) && (pack_zero || (pack_cnt != '0))) begin
          ram_we    = 1'b1;
          ram_waddr = k[AW-1:0];
          ram_wdata = pack_zero ? '0 : (OW'(cur_slot) + OW'(1));
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // result selection for the output register
  always_comb begin
    emit      = 1'b0;
    out_code  = boa_pkg::RC_OK;
    out_index = pend_addr;
    out_owner = '0;
    out_valid = 1'b0;
    out_free  = '0;
    out_files = '0;
    out_last  = 1'b1;
    if (need_emit && can_emit) begin
      emit      = 1'b1;
      out_valid = 1'b1;
      if (op == boa_pkg::FN_MAP) begin
        out_owner = cur_own;
        out_last  = ((CW'(pend_addr) + CW'(1)) == scan_end);
      end else begin
        out_last  = ((k + CW'(1)) == tally);
      end
    end else if ((state == ST_RESP) && can_emit) begin
      emit      = 1'b1;
      out_code  = resp_code;
      out_index = '0;
      out_free  = resp_free;
      out_files = resp_files;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {(boa_pkg::M_DATA_W - 25)'(0), out_files, out_free, out_owner,
                  out_index, out_code};
      m_tuser <= out_valid;
      m_tlast <= out_last;
    end
  end

  // entry valid bits mask the ram until each entry is written
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ram_waddr] <= 1'b1;
    end
  end

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == boa_pkg::REG_ACTIVE_BLOCKS);
  assign prdata = (paddr[2] == boa_pkg::REG_ACTIVE_BLOCKS) ?
                  boa_pkg::APB_D_W'(active_blocks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_blocks <= boa_pkg::ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_blocks <= pwdata[boa_pkg::ACTIVE_W-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE);

  // per-slot block counters for compaction, one lane per slot
  always_ff @(posedge clk) begin
    for (int s = 0; s < boa_pkg::MAX_FILES; s++) begin
      if ((state == ST_IDLE) && s_tvalid) begin
        cnt[s] <= '0;
      end else if ((state == ST_SCAN1) && pend && (cur_own == OW'(s + 1))) begin
        cnt[s] <= cnt[s] + CW'(1);
      end else if ((state == ST_PACK) && ram_we && !pack_zero &&
                   (cur_slot[SW-1:0] == SW'(s))) begin
        cnt[s] <= cnt[s] - CW'(1);
      end
    end
  end

  // sequencer: walk the owner ram and step through the passes of each request
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_present  <= '0;
      files_present <= '0;
      pend          <= 1'b0;
      rd_addr       <= '0;
      k             <= '0;
      tally         <= '0;
      cur_slot      <= '0;
    end else begin
      // read pipeline bookkeeping
      if (in_scan && !stall) begin
        pend <= ram_re;
        if (ram_re) begin
          rd_addr   <= rd_addr + CW'(1);
          pend_addr <= rd_addr[AW-1:0];
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op         <= s_tuser;
            slot       <= s_tdata[SW-1:0];
            count      <= s_tdata[SW +: boa_pkg::COUNT_W];
            rd_addr    <= '0;
            pend       <= 1'b0;
            tally      <= '0;
            k          <= '0;
            cur_slot   <= '0;
            resp_free  <= '0;
            resp_files <= '0;
            case (s_tuser)
              boa_pkg::FN_CREATE: begin
                scan_end <= act;
                if (slot_present[s_tdata[SW-1:0]]) begin
                  resp_code <= boa_pkg::RC_EXISTS;
                  state     <= ST_RESP;
                end else begin
                  resp_code <= boa_pkg::RC_OK;
                  state     <= ST_SCAN1;
                end
              end
              boa_pkg::FN_DELETE: begin
                scan_end <= CW'(boa_pkg::BLOCKS);
                if (slot_present[s_tdata[SW-1:0]]) begin
                  resp_code <= boa_pkg::RC_OK;
                  state     <= ST_SCAN2;
                end else begin
                  resp_code <= boa_pkg::RC_NOFILE;
                  state     <= ST_RESP;
                end
              end
              boa_pkg::FN_READ: begin
                scan_end <= act;
                if (slot_present[s_tdata[SW-1:0]]) begin
                  resp_code <= boa_pkg::RC_OK;
                  state     <= ST_SCAN1;
                end else begin
                  resp_code <= boa_pkg::RC_NOFILE;
                  state     <= ST_RESP;
                end
              end
              boa_pkg::FN_DEFRAG: begin
                scan_end  <= CW'(boa_pkg::BLOCKS);
                resp_code <= boa_pkg::RC_OK;
                state     <= ST_SCAN1;
              end
              boa_pkg::FN_STATUS: begin
                scan_end  <= act;
                resp_code <= boa_pkg::RC_OK;
                state     <= ST_SCAN1;
              end
              boa_pkg::FN_MAP: begin
                scan_end  <= act;
                resp_code <= boa_pkg::RC_OK;
                state     <= (act == '0) ? ST_RESP : ST_SCAN2;
              end
              default: begin
                scan_end  <= '0;
                resp_code <= boa_pkg::RC_OK;
                state     <= ST_RESP;
              end
            endcase
          end
        end

        // counting pass: free blocks, or blocks of the slot
        ST_SCAN1: begin
          if (pend) begin
            if (((op == boa_pkg::FN_CREATE) || (op == boa_pkg::FN_STATUS)) &&
                (cur_own == '0)) begin
              tally <= tally + CW'(1);
            end else if ((op == boa_pkg::FN_READ) && (cur_own == slot_own)) begin
              tally <= tally + CW'(1);
            end
          end
          if (scan_done) begin
            rd_addr <= '0;
            k       <= '0;
            case (op)
              boa_pkg::FN_CREATE: begin
                if (tally < CW'(count)) begin
                  resp_code <= boa_pkg::RC_NOSPACE;
                  state     <= ST_RESP;
                end else begin
                  state <= ST_SCAN2;
                end
              end
              boa_pkg::FN_READ: begin
                state <= (tally == '0) ? ST_RESP : ST_SCAN2;
              end
              boa_pkg::FN_STATUS: begin
                resp_free  <= tally;
                resp_files <= files_present;
                state      <= ST_RESP;
              end
              default: begin
                cur_slot <= '0;
                state    <= ST_PACK;
              end
            endcase
          end
        end

        // action pass: claim, free or report entries
        ST_SCAN2: begin
          if (ram_we || emit) begin
            k <= k + CW'(1);
          end
          if (scan_done) begin
            case (op)
              boa_pkg::FN_CREATE: begin
                slot_present[slot] <= 1'b1;
                files_present      <= files_present + boa_pkg::FILES_W'(1);
                state              <= ST_RESP;
              end
              boa_pkg::FN_DELETE: begin
                slot_present[slot] <= 1'b0;
                files_present      <= files_present - boa_pkg::FILES_W'(1);
                state              <= ST_RESP;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end

        // compaction: lay slots down from block 0, then fill with free
        ST_PACK: begin
          if (k == CW'(boa_pkg::BLOCKS)) begin
            state <= ST_RESP;
          end else if (ram_we) begin
            k <= k + CW'(1);
          end else begin
            cur_slot <= cur_slot + (SW+1)'(1);
          end
        end

        ST_RESP: begin
          if (can_emit) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `BOA_ASSERT_NEXT(a_one_request_at_a_time, s_tvalid && s_tready, !s_tready,
                   "request taken while another is in progress")
  `BOA_ASSERT_NOW(a_no_same_entry_rw, ram_we && ram_re, ram_waddr != ram_raddr,
                  "owner ram read and written at the same entry")
  `BOA_ASSERT_NOW(a_file_count_matches, 1'b1,
                  $countones(slot_present) == files_present,
                  "file count differs from present slots")
  `BOA_ASSERT_NOW(a_pack_slot_range, state == ST_PACK,
                  cur_slot <= (SW+1)'(boa_pkg::MAX_FILES),
                  "compaction slot pointer out of range")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for block_owner_allocator_unit: a directed table, then random requests
// under several active_blocks settings; depends on boa_pkg and the allocator rtl

module testbench;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 80;     // margin after the final result before a register write
  localparam int PHASE_ITEMS   = 41;
  localparam int PHASES        = 5;

  // func values the block does not use
  localparam logic [boa_pkg::FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [boa_pkg::FUNC_W-1:0] FN_RSVD7 = 3'd7;

  typedef struct {
    logic [boa_pkg::CODE_W-1:0]  code;
    logic [boa_pkg::ADDR_W-1:0]  blk_idx;
    boa_pkg::owner_t             blk_owner;
    logic                        blk_valid;
    logic [boa_pkg::CNT_W-1:0]   free_blks;
    logic [boa_pkg::FILES_W-1:0] file_cnt;
    logic                        last;
  } fs_result_t;

  // directed row: request fields, then a typed single result where one is given
  typedef struct {
    logic [boa_pkg::FUNC_W-1:0]  fn;
    logic [boa_pkg::SLOT_W-1:0]  slot;
    logic [boa_pkg::COUNT_W-1:0] cnt;
    bit                          typed;
    logic [boa_pkg::CODE_W-1:0]  code;
    logic [boa_pkg::CNT_W-1:0]   free_blks;
    logic [boa_pkg::FILES_W-1:0] file_cnt;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [boa_pkg::S_DATA_W-1:0]  s_tdata = '0;   // [3:0] file_slot, [10:4] block_count
  logic [boa_pkg::FUNC_W-1:0]    s_tuser = '0;   // [2:0] func
  logic                          m_tvalid;
  logic                          m_tready = 1'b1;
  logic [boa_pkg::M_DATA_W-1:0]  m_tdata;        // [1:0] result_code, [7:2] block_index,
                                                 // [12:8] block_owner, [19:13] free_blocks,
                                                 // [24:20] file_count
  logic                          m_tuser;        // [0] block_valid
  logic                          m_tlast;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [boa_pkg::APB_A_W-1:0]   paddr = '0;
  logic [boa_pkg::APB_D_W-1:0]   pwdata = '0;
  logic [boa_pkg::APB_D_W-1:0]   prdata;
  logic                          pready;

  // predicted allocator state
  boa_pkg::owner_t owner_map [boa_pkg::BLOCKS];
  bit              slot_used [boa_pkg::MAX_FILES];
  int              file_total;
  int              active_cfg;
  fs_result_t      pending_results [$];

  int fail_count  = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;

  dir_row_t directed_rows [27] = '{
    '{boa_pkg::FN_STATUS, 4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd50, 5'd0},
    '{boa_pkg::FN_READ,   4'd3,  7'd0,  1'b1, boa_pkg::RC_NOFILE,  7'd0,  5'd0},
    '{boa_pkg::FN_DELETE, 4'd3,  7'd0,  1'b1, boa_pkg::RC_NOFILE,  7'd0,  5'd0},
    '{boa_pkg::FN_MAP,    4'd0,  7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_READ,   4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd0,  7'd5,  1'b1, boa_pkg::RC_EXISTS,  7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd15, 7'd64, 1'b1, boa_pkg::RC_NOSPACE, 7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd15, 7'd10, 1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd1,  7'd7,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd2,  7'd3,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_DELETE, 4'd1,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_READ,   4'd15, 7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd4,  7'd12, 1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_STATUS, 4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd25, 5'd4},
    '{boa_pkg::FN_MAP,    4'd0,  7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_DEFRAG, 4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_MAP,    4'd0,  7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_READ,   4'd4,  7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{FN_RSVD6,           4'd10, 7'd42, 1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{FN_RSVD7,           4'd5,  7'd33, 1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd5,  7'd26, 1'b1, boa_pkg::RC_NOSPACE, 7'd0,  5'd0},
    '{boa_pkg::FN_CREATE, 4'd5,  7'd25, 1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_STATUS, 4'd0,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd5},
    '{boa_pkg::FN_CREATE, 4'd6,  7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_DELETE, 4'd15, 7'd0,  1'b1, boa_pkg::RC_OK,      7'd0,  5'd0},
    '{boa_pkg::FN_READ,   4'd5,  7'd0,  1'b0, boa_pkg::RC_OK,      7'd0,  5'd0}
  };

  block_owner_allocator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // queue one predicted result behind those already waiting
  task automatic queue_result(input fs_result_t r);
    pending_results = {pending_results, r};
  endtask

  // apply one request to the predicted table and queue the results it causes
  task automatic apply_fs_request(input logic [boa_pkg::FUNC_W-1:0] fn,
                                  input logic [boa_pkg::SLOT_W-1:0] slot,
                                  input logic [boa_pkg::COUNT_W-1:0] cnt);
    int              act;
    int              nfree;
    int              total;
    int              k;
    boa_pkg::owner_t tag;
    boa_pkg::owner_t compacted [boa_pkg::BLOCKS];
    fs_result_t      r;
    act   = (active_cfg > boa_pkg::BLOCKS) ? boa_pkg::BLOCKS : active_cfg;
    tag   = boa_pkg::owner_t'(slot) + boa_pkg::owner_t'(1);
    nfree = 0;
    total = 0;
    for (int i = 0; i < act; i++) begin
      if (owner_map[i] == '0) nfree++;
      if (owner_map[i] == tag) total++;
    end
    r = '{default: '0};
    r.last = 1'b1;
    case (fn)
      boa_pkg::FN_CREATE: begin
        if (slot_used[slot]) begin
          r.code = boa_pkg::RC_EXISTS;
        end else if (nfree < int'(cnt)) begin
          r.code = boa_pkg::RC_NOSPACE;
        end else begin
          // first fit over the active blocks
          k = 0;
          for (int i = 0; i < act && k < int'(cnt); i++) begin
            if (owner_map[i] == '0) begin
              owner_map[i] = tag;
              k++;
            end
          end
          slot_used[slot] = 1'b1;
          file_total++;
        end
        queue_result(r);
      end
      boa_pkg::FN_DELETE: begin
        if (!slot_used[slot]) begin
          r.code = boa_pkg::RC_NOFILE;
        end else begin
          // frees the slot across the whole table, not just active blocks
          for (int i = 0; i < boa_pkg::BLOCKS; i++)
            if (owner_map[i] == tag) owner_map[i] = '0;
          slot_used[slot] = 1'b0;
          file_total--;
        end
        queue_result(r);
      end
      boa_pkg::FN_READ: begin
        if (!slot_used[slot]) begin
          r.code = boa_pkg::RC_NOFILE;
          queue_result(r);
        end else if (total == 0) begin
          queue_result(r);
        end else begin
          k = 0;
          for (int i = 0; i < act; i++) begin
            if (owner_map[i] == tag) begin
              k++;
              r.blk_idx   = boa_pkg::ADDR_W'(i);
              r.blk_valid = 1'b1;
              r.last      = (k == total);
              queue_result(r);
            end
          end
        end
      end
      boa_pkg::FN_DEFRAG: begin
        // pack owned blocks from block 0, slot by slot
        for (int i = 0; i < boa_pkg::BLOCKS; i++) compacted[i] = '0;
        k = 0;
        for (int s = 0; s < boa_pkg::MAX_FILES; s++) begin
          if (slot_used[s]) begin
            for (int i = 0; i < boa_pkg::BLOCKS; i++) begin
              if (owner_map[i] == boa_pkg::owner_t'(s + 1) && k < boa_pkg::BLOCKS) begin
                compacted[k] = boa_pkg::owner_t'(s + 1);
                k++;
              end
            end
          end
        end
        owner_map = compacted;
        queue_result(r);
      end
      boa_pkg::FN_STATUS: begin
        r.free_blks = boa_pkg::CNT_W'(nfree);
        r.file_cnt  = boa_pkg::FILES_W'(file_total);
        queue_result(r);
      end
      boa_pkg::FN_MAP: begin
        if (act == 0) begin
          queue_result(r);
        end else begin
          for (int i = 0; i < act; i++) begin
            r.blk_idx   = boa_pkg::ADDR_W'(i);
            r.blk_owner = owner_map[i];
            r.blk_valid = 1'b1;
            r.last      = (i + 1 == act);
            queue_result(r);
          end
        end
      end
      default: queue_result(r);
    endcase
  endtask

  // present one request and wait for it to be taken
  task automatic issue_request(input logic [boa_pkg::FUNC_W-1:0] fn,
                               input logic [boa_pkg::SLOT_W-1:0] slot,
                               input logic [boa_pkg::COUNT_W-1:0] cnt);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = fn;
    s_tdata  = boa_pkg::S_DATA_W'({cnt, slot});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_fs_request(fn, slot, cnt);
  endtask

  // wait until every predicted result has come back and the block has settled
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write active_blocks, then read it back
  task automatic write_active_blocks(input int value);
    logic [boa_pkg::APB_D_W-1:0] got;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {boa_pkg::REG_ACTIVE_BLOCKS, 2'b00};
    pwdata  = boa_pkg::APB_D_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    active_cfg = value;
    if (got !== boa_pkg::APB_D_W'(value)) begin
      $error("active_blocks readback: expected %0d, got %0d", value, got);
      fail_count++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // receiver stalls in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    fs_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_code", want.code, m_tdata[1:0]);
        check_field("block_index", want.blk_idx, m_tdata[7:2]);
        check_field("block_owner", want.blk_owner, m_tdata[12:8]);
        check_field("free_blocks", want.free_blks, m_tdata[19:13]);
        check_field("file_count", want.file_cnt, m_tdata[24:20]);
        check_field("block_valid", want.blk_valid, m_tuser);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    fs_result_t                  typed_r;
    logic [boa_pkg::FUNC_W-1:0]  fn;
    logic [boa_pkg::SLOT_W-1:0]  slot;
    logic [boa_pkg::COUNT_W-1:0] cnt;
    int                          roll;
    int                          cfg;

    for (int i = 0; i < boa_pkg::BLOCKS; i++) owner_map[i] = '0;
    for (int s = 0; s < boa_pkg::MAX_FILES; s++) slot_used[s] = 1'b0;
    file_total = 0;
    active_cfg = boa_pkg::ACTIVE_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      issue_request(directed_rows[r].fn, directed_rows[r].slot, directed_rows[r].cnt);
      if (directed_rows[r].typed) begin
        typed_r = '{default: '0};
        typed_r.code      = directed_rows[r].code;
        typed_r.free_blks = directed_rows[r].free_blks;
        typed_r.file_cnt  = directed_rows[r].file_cnt;
        typed_r.last      = 1'b1;
        void'(pending_results.pop_back());
        queue_result(typed_r);
      end
    end

    // random phases under different disk sizes, shrinking the disk after full-size phases
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       cfg = boa_pkg::BLOCKS;
        1:       cfg = 1;
        2:       cfg = $urandom_range(2, boa_pkg::BLOCKS - 1);
        3:       cfg = boa_pkg::BLOCKS;
        default: cfg = $urandom_range(8, 40);
      endcase
      write_active_blocks(cfg);
      calm = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        slot = boa_pkg::SLOT_W'($urandom_range(0, boa_pkg::MAX_FILES - 1));
        cnt  = boa_pkg::COUNT_W'($urandom_range(0, boa_pkg::BLOCKS));
        if (roll < 38) begin
          fn = boa_pkg::FN_CREATE;
          if ($urandom_range(0, 7) != 0) cnt = boa_pkg::COUNT_W'($urandom_range(0, 8));
        end else if (roll < 55) begin
          fn = boa_pkg::FN_DELETE;
        end else if (roll < 70) begin
          fn = boa_pkg::FN_READ;
        end else if (roll < 78) begin
          fn = boa_pkg::FN_DEFRAG;
        end else if (roll < 87) begin
          fn = boa_pkg::FN_STATUS;
        end else if (roll < 96) begin
          fn = boa_pkg::FN_MAP;
        end else begin
          fn = $urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7;
        end
        issue_request(fn, slot, cnt);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
